@@ rtl/gregorian_date_offset_macros.svh @@
// Assertion macros for the Gregorian date offset block.
`ifndef GREGORIAN_DATE_OFFSET_MACROS_SVH
`define GREGORIAN_DATE_OFFSET_MACROS_SVH
`ifndef SYNTH
`define GDO_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdo implication check failed");
`define GDO_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdo next-cycle check failed");
`else
`define GDO_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define GDO_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/gdo_pkg.sv @@
// Types, constants and calendar functions shared by the date offset modules.
package gdo_pkg;

    localparam logic [13:0] YEAR_MIN       = 14'd1;
    localparam logic [13:0] YEAR_MAX       = 14'd9999;
    localparam logic [3:0]  MONTH_FIRST    = 4'd1;
    localparam logic [3:0]  MONTH_LAST     = 4'd12;
    localparam logic [8:0]  CYCLE_YEARS    = 9'd400;
    localparam logic [8:0]  CYCLE_LAST     = 9'd399;
    localparam logic [8:0]  DAYS_YEAR      = 9'd365;
    localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHK,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_MOD400,
        OP_START,
        OP_YR_BACK,
        OP_YR_FWD,
        OP_MONTH
    } t_alu_op;

    typedef struct packed {
        logic sum_neg;
        logic rem_neg;
        logic date_ok;
        logic wy_min;
        logic wy_max;
        logic wm_last;
    } t_status;

    typedef struct packed {
        logic    in_ready;
        logic    out_valid;
        t_alu_op alu_op;
        logic    ld_in;
        logic    mod_step;
        logic    mod_done;
        logic    start;
        logic    start_err;
        logic    yr_back;
        logic    yr_fwd;
        logic    walk_err;
        logic    mon_step;
        logic    mon_done;
    } t_ctrl;

    // Leap year test on the year taken modulo 400.
    function automatic logic leap_of(input logic [8:0] r400);
        return (r400[1:0] == 2'b00) && (r400 != 9'd100) && (r400 != 9'd200) &&
               (r400 != 9'd300);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the year before the first of month m.
    function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        if (leap && (m > 4'd2)) begin
            n = n + 9'd1;
        end
        return n;
    endfunction

endpackage

@@ rtl/gdo_if.sv @@
// Valid/ready channel interfaces for the request and result items.
interface gdo_in_if #(
    parameter int OFFSET_BITS = 17
) ();
    logic                          valid;
    logic                          ready;
    logic [4:0]                    in_day;
    logic [3:0]                    in_month;
    logic [13:0]                   in_year;
    logic signed [OFFSET_BITS-1:0] day_offset;

    modport source (output valid, output in_day, output in_month, output in_year,
                    output day_offset, input ready);
    modport sink   (input valid, input in_day, input in_month, input in_year,
                    input day_offset, output ready);
endinterface

interface gdo_out_if ();
    logic        valid;
    logic        ready;
    logic        is_leap;
    logic [8:0]  day_of_year;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic        error;

    modport source (output valid, output is_leap, output day_of_year, output out_day,
                    output out_month, output out_year, output error, input ready);
    modport sink   (input valid, input is_leap, input day_of_year, input out_day,
                    input out_month, input out_year, input error, output ready);
endinterface

@@ rtl/gregorian_date_offset.sv @@
// The shared adder walks whole years, then whole months, one per cycle, after reducing
// the year modulo 400 by repeated subtract; the result then waits until the output is taken.
// Throughput: one item at a time; a new item is taken only after the result is delivered.
// Reset is synchronous and active low; it returns the sequencer to idle and drops valid.
`include "gregorian_date_offset_macros.svh"

module gregorian_date_offset #(
    parameter int OFFSET_BITS = 17
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gdo_in_if.sink     i_req,
    gdo_out_if.source  o_rsp
);

    localparam int RW = (OFFSET_BITS + 2 > 15) ? OFFSET_BITS + 2 : 15;

    gdo_pkg::t_ctrl   ctrl;
    gdo_pkg::t_status stat;

    logic [4:0]                    r_day;
    logic [3:0]                    r_month;
    logic [13:0]                   r_year;
    logic signed [OFFSET_BITS-1:0] r_off;
    logic signed [RW-1:0]          r_rem;
    logic [8:0]                    r_r400;
    logic [13:0]                   r_wy;
    logic [3:0]                    r_wm;
    logic                          r_leap;
    logic [8:0]                    r_doy;
    logic [4:0]                    r_o_day;
    logic [3:0]                    r_o_month;
    logic [13:0]                   r_o_year;
    logic                          r_o_err;

    logic                 leap_cur;
    logic                 leap_prev;
    logic [8:0]           r400_dec;
    logic [8:0]           r400_inc;
    logic [8:0]           doy;
    logic [8:0]           ylen_cur;
    logic [8:0]           ylen_prev;
    logic [4:0]           mlen;
    logic signed [RW-1:0] off_ext;
    logic signed [RW-1:0] sum;
    logic                 sum_neg;
    logic                 req_accept;
    logic                 rsp_good;
    logic                 rsp_day_ok;
    logic                 rsp_year_ok;

    assign r400_dec  = (r_r400 == 9'd0) ? gdo_pkg::CYCLE_LAST : r_r400 - 9'd1;
    assign r400_inc  = (r_r400 == gdo_pkg::CYCLE_LAST) ? 9'd0 : r_r400 + 9'd1;
    assign leap_cur  = gdo_pkg::leap_of(r_r400);
    assign leap_prev = gdo_pkg::leap_of(r400_dec);
    assign ylen_cur  = leap_cur ? gdo_pkg::DAYS_LEAP_YEAR : gdo_pkg::DAYS_YEAR;
    assign ylen_prev = leap_prev ? gdo_pkg::DAYS_LEAP_YEAR : gdo_pkg::DAYS_YEAR;
    assign mlen      = gdo_pkg::month_len(r_wm, leap_cur);
    assign doy       = gdo_pkg::days_before_month(r_month, leap_cur) + {4'd0, r_day};
    assign off_ext   = {{(RW-OFFSET_BITS){r_off[OFFSET_BITS-1]}}, r_off};

    assign stat.sum_neg = sum_neg;
    assign stat.rem_neg = r_rem[RW-1];
    assign stat.date_ok = (r_year >= gdo_pkg::YEAR_MIN) && (r_year <= gdo_pkg::YEAR_MAX) &&
                          (r_month >= gdo_pkg::MONTH_FIRST) &&
                          (r_month <= gdo_pkg::MONTH_LAST) && (r_day != 5'd0) &&
                          (r_day <= gdo_pkg::month_len(r_month, leap_cur));
    assign stat.wy_min  = (r_wy == gdo_pkg::YEAR_MIN);
    assign stat.wy_max  = (r_wy == gdo_pkg::YEAR_MAX);
    assign stat.wm_last = (r_wm == gdo_pkg::MONTH_LAST);

    gdo_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    gdo_alu #(
        .RW (RW)
    ) u_alu (
        .i_op        (ctrl.alu_op),
        .i_rem       (r_rem),
        .i_off       (off_ext),
        .i_doy_m1    (doy - 9'd1),
        .i_ylen_cur  (ylen_cur),
        .i_ylen_prev (ylen_prev),
        .i_mlen      (mlen),
        .o_sum       (sum),
        .o_sum_neg   (sum_neg)
    );

    always_ff @(posedge i_clk) begin
        if (ctrl.ld_in) begin
            r_day   <= i_req.in_day;
            r_month <= i_req.in_month;
            r_year  <= i_req.in_year;
            r_off   <= i_req.day_offset;
            r_rem   <= {{(RW-14){1'b0}}, i_req.in_year};
        end
        if (ctrl.mod_step) begin
            r_rem <= sum;
        end
        if (ctrl.mod_done) begin
            r_r400 <= r_rem[8:0];
        end
        if (ctrl.start || ctrl.start_err) begin
            r_leap <= leap_cur;
            r_doy  <= ctrl.start ? doy : 9'd0;
        end
        if (ctrl.start) begin
            r_rem <= sum;
            r_wy  <= r_year;
            r_wm  <= gdo_pkg::MONTH_FIRST;
        end
        if (ctrl.yr_back) begin
            r_rem  <= sum;
            r_wy   <= r_wy - 14'd1;
            r_r400 <= r400_dec;
        end
        if (ctrl.yr_fwd) begin
            r_rem  <= sum;
            r_wy   <= r_wy + 14'd1;
            r_r400 <= r400_inc;
        end
        if (ctrl.mon_step) begin
            r_rem <= sum;
            r_wm  <= r_wm + 4'd1;
        end
        if (ctrl.start_err || ctrl.walk_err) begin
            r_o_day   <= r_day;
            r_o_month <= r_month;
            r_o_year  <= r_year;
            r_o_err   <= 1'b1;
        end
        if (ctrl.mon_done) begin
            r_o_day   <= r_rem[4:0] + 5'd1;
            r_o_month <= r_wm;
            r_o_year  <= r_wy;
            r_o_err   <= 1'b0;
        end
    end

    assign i_req.ready       = ctrl.in_ready;
    assign o_rsp.valid       = ctrl.out_valid;
    assign o_rsp.is_leap     = r_leap;
    assign o_rsp.day_of_year = r_doy;
    assign o_rsp.out_day     = r_o_day;
    assign o_rsp.out_month   = r_o_month;
    assign o_rsp.out_year    = r_o_year;
    assign o_rsp.error       = r_o_err;

    assign req_accept  = i_req.valid && i_req.ready;
    assign rsp_good    = o_rsp.valid && !o_rsp.error;
    assign rsp_day_ok  = (o_rsp.out_day != 5'd0) &&
                         (o_rsp.out_day <= gdo_pkg::month_len(o_rsp.out_month, leap_cur));
    assign rsp_year_ok = (o_rsp.out_year >= gdo_pkg::YEAR_MIN) &&
                         (o_rsp.out_year <= gdo_pkg::YEAR_MAX) &&
                         (o_rsp.day_of_year != 9'd0);

    `GDO_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_rsp.valid, !i_req.ready)
    `GDO_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, req_accept, !i_req.ready && !o_rsp.valid)
    `GDO_ASSERT_IMPL(a_day_fits_month, i_clk, i_rst_n, rsp_good, rsp_day_ok)
    `GDO_ASSERT_IMPL(a_year_in_range, i_clk, i_rst_n, rsp_good, rsp_year_ok)

endmodule

@@ rtl/gdo_alu.sv @@
// Shared add/subtract unit that serves every step of the date walk.
module gdo_alu #(
    parameter int RW = 19
) (
    input  gdo_pkg::t_alu_op i_op,
    input  logic signed [RW-1:0] i_rem,
    input  logic signed [RW-1:0] i_off,
    input  logic [8:0]           i_doy_m1,
    input  logic [8:0]           i_ylen_cur,
    input  logic [8:0]           i_ylen_prev,
    input  logic [4:0]           i_mlen,
    output logic signed [RW-1:0] o_sum,
    output logic                 o_sum_neg
);

    logic signed [RW-1:0] a;
    logic [8:0]           b_mag;
    logic                 sub;

    always_comb begin
        a     = i_rem;
        b_mag = gdo_pkg::CYCLE_YEARS;
        sub   = 1'b1;
        case (i_op)
            gdo_pkg::OP_MOD400: begin
                b_mag = gdo_pkg::CYCLE_YEARS;
                sub   = 1'b1;
            end
            gdo_pkg::OP_START: begin
                a     = i_off;
                b_mag = i_doy_m1;
                sub   = 1'b0;
            end
            gdo_pkg::OP_YR_BACK: begin
                b_mag = i_ylen_prev;
                sub   = 1'b0;
            end
            gdo_pkg::OP_YR_FWD: begin
                b_mag = i_ylen_cur;
                sub   = 1'b1;
            end
            gdo_pkg::OP_MONTH: begin
                b_mag = {4'd0, i_mlen};
                sub   = 1'b1;
            end
            default: begin
                b_mag = gdo_pkg::CYCLE_YEARS;
                sub   = 1'b1;
            end
        endcase
    end

    assign o_sum     = sub ? (a - $signed({{(RW-9){1'b0}}, b_mag}))
                           : (a + $signed({{(RW-9){1'b0}}, b_mag}));
    assign o_sum_neg = o_sum[RW-1];

endmodule

@@ rtl/gdo_seq.sv @@
// Sequencer that steps the year reduction, year walk and month walk.
module gdo_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  gdo_pkg::t_status i_stat,
    output gdo_pkg::t_ctrl   o_ctrl
);

    gdo_pkg::t_state r_state;
    gdo_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gdo_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = gdo_pkg::ST_MOD;
                end
            end
            gdo_pkg::ST_MOD: begin
                if (i_stat.sum_neg) begin
                    n_state = gdo_pkg::ST_CHK;
                end
            end
            gdo_pkg::ST_CHK: begin
                n_state = i_stat.date_ok ? gdo_pkg::ST_YEAR : gdo_pkg::ST_DONE;
            end
            gdo_pkg::ST_YEAR: begin
                if (i_stat.rem_neg) begin
                    if (i_stat.wy_min) begin
                        n_state = gdo_pkg::ST_DONE;
                    end
                end else if (!i_stat.sum_neg) begin
                    if (i_stat.wy_max) begin
                        n_state = gdo_pkg::ST_DONE;
                    end
                end else begin
                    n_state = gdo_pkg::ST_MONTH;
                end
            end
            gdo_pkg::ST_MONTH: begin
                if (i_stat.wm_last || i_stat.sum_neg) begin
                    n_state = gdo_pkg::ST_DONE;
                end
            end
            gdo_pkg::ST_DONE: begin
                if (i_out_ready) begin
                    n_state = gdo_pkg::ST_IDLE;
                end
            end
            default: n_state = gdo_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl        = '0;
        o_ctrl.alu_op = gdo_pkg::OP_MOD400;
        case (r_state)
            gdo_pkg::ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.ld_in    = i_in_valid;
            end
            gdo_pkg::ST_MOD: begin
                o_ctrl.alu_op   = gdo_pkg::OP_MOD400;
                o_ctrl.mod_step = !i_stat.sum_neg;
                o_ctrl.mod_done = i_stat.sum_neg;
            end
            gdo_pkg::ST_CHK: begin
                o_ctrl.alu_op    = gdo_pkg::OP_START;
                o_ctrl.start     = i_stat.date_ok;
                o_ctrl.start_err = !i_stat.date_ok;
            end
            gdo_pkg::ST_YEAR: begin
                if (i_stat.rem_neg) begin
                    o_ctrl.alu_op   = gdo_pkg::OP_YR_BACK;
                    o_ctrl.yr_back  = !i_stat.wy_min;
                    o_ctrl.walk_err = i_stat.wy_min;
                end else begin
                    o_ctrl.alu_op   = gdo_pkg::OP_YR_FWD;
                    o_ctrl.yr_fwd   = !i_stat.sum_neg && !i_stat.wy_max;
                    o_ctrl.walk_err = !i_stat.sum_neg && i_stat.wy_max;
                end
            end
            gdo_pkg::ST_MONTH: begin
                o_ctrl.alu_op   = gdo_pkg::OP_MONTH;
                o_ctrl.mon_step = !i_stat.wm_last && !i_stat.sum_neg;
                o_ctrl.mon_done = i_stat.wm_last || i_stat.sum_neg;
            end
            gdo_pkg::ST_DONE: begin
                o_ctrl.out_valid = 1'b1;
            end
            default: begin
                o_ctrl.in_ready = 1'b0;
            end
        endcase
    end

endmodule
